FILE: design/epsc_pkg.sv
// shared constants, tables and helpers for the epoch seconds to calendar converter
package epsc_pkg;

    // input and output payload widths
    localparam int InWidth  = 32;
    localparam int OutWidth = 48;

    // seconds from 1970-01-01 00:00 to 1979-12-31 16:00, taken as the start of 1980
    localparam logic [InWidth-1:0] EpochShift = 32'd315504000;
    localparam logic [11:0]        BaseYear   = 12'd1980;

    // field widths of a result
    localparam int YearW  = 12;
    localparam int MonthW = 4;
    localparam int DomW   = 5;
    localparam int HourW  = 5;
    localparam int MinW   = 6;
    localparam int SecW   = 6;
    localparam int WdayW  = 3;

    // pipeline depth from input accept to output register
    localparam int Stages = 11;

    // cumulative days at the start of each year of a four-year group
    localparam logic [10:0] YearStart [0:3] = '{11'd0, 11'd366, 11'd731, 11'd1096};

    // cumulative days at the start of each month
    localparam logic [8:0] MonthStartNorm [0:12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
    };
    localparam logic [8:0] MonthStartLeap [0:12] = '{
        9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
        9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366
    };

    // weekday offset for each year of a group
    localparam logic [2:0] WeekOffset [0:3] = '{3'd1, 3'd3, 3'd4, 3'd5};

    // x mod 7 for a 10-bit value, using 8 = 1 (mod 7)
    function automatic logic [2:0] mod7_10(input logic [9:0] x);
        logic [4:0] s1;
        logic [3:0] s2;
        s1 = 5'(x[2:0]) + 5'(x[5:3]) + 5'(x[8:6]) + 5'(x[9]);
        s2 = 4'(s1[2:0]) + 4'(s1[4:3]);
        if (s2 >= 4'd7) begin
            s2 = s2 - 4'd7;
        end
        return s2[2:0];
    endfunction

endpackage

FILE: design/epsc_cdiv.sv
// three-stage pipelined division by a constant: reciprocal multiply then one correction
module epsc_cdiv
    import epsc_pkg::*;
#(
    parameter int WN  = 25,
    parameter int DIV = 675,
    parameter int WQ  = 16,
    parameter int WR  = 10
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [WN-1:0] i_num,
    output logic [WQ-1:0] o_q,
    output logic [WR-1:0] o_r
);

    // floor(2^WN / DIV): the estimate is the true quotient or one below it
    localparam logic [WN-1:0] Recip = WN'((64'd1 << WN) / 64'(DIV));
    localparam logic [WN-1:0] DivW  = WN'(DIV);

    logic [2*WN-1:0] r_prod;
    logic [WN-1:0]   r_num1;
    logic [WN-1:0]   r_qest;
    logic [WN-1:0]   r_rest;
    logic [WQ-1:0]   r_q;
    logic [WR-1:0]   r_r;

    logic [WN-1:0]   w_qest;
    logic [WN-1:0]   w_rest;

    always_comb begin
        w_qest = r_prod[2*WN-1:WN];
        w_rest = r_num1 - WN'(w_qest * DivW);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= (2*WN)'(i_num) * (2*WN)'(Recip);
            r_num1 <= i_num;
            r_qest <= w_qest;
            r_rest <= w_rest;
            if (r_rest >= DivW) begin
                r_q <= WQ'(r_qest + WN'(1));
                r_r <= WR'(r_rest - DivW);
            end else begin
                r_q <= WQ'(r_qest);
                r_r <= WR'(r_rest);
            end
        end
    end

    assign o_q = r_q;
    assign o_r = r_r;

endmodule

FILE: design/epoch_seconds_to_calendar_top.sv
// top level of the epoch seconds to calendar converter
// throughput: one request per cycle while the output is not stalled; the whole pipeline advances together
// a stall on the output holds every stage, nothing is dropped or repeated
// reset (synchronous, active low) clears the valid pipe; payload is not reset
// the depth is set by the chain of three constant dividers and the calendar lookup
module epoch_seconds_to_calendar_top
    import epsc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [InWidth-1:0]  i_s_tdata,   // [31:0] unix_seconds
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [OutWidth-1:0] o_m_tdata    // [0] valid_res, [12:1] year, [16:13] month,
                                             // [21:17] day_of_month, [26:22] hour,
                                             // [32:27] minute, [38:33] second,
                                             // [41:39] weekday, [47:42] zero
);

    // global advance: move when the output stage is empty or being taken
    logic w_en;

    // valid bit and in-range flag for every stage
    logic [Stages:1] r_vld;
    logic [Stages:1] r_ok;

    // stage 1: rebased seconds
    logic [31:0] r1_t;
    // stages 2..4: low seconds bits that bypass the day divider
    logic [6:0]  r2_low, r3_low, r4_low;

    // day divider on seconds / 128, by 675 (86400 = 128 * 675)
    logic [15:0] w_days;
    logic [9:0]  w_sod_hi;
    logic [16:0] w_sod;

    // second-of-day by 60, days by 1461
    logic [10:0] w_min_total;
    logic [5:0]  w_sec;
    logic [5:0]  w_grp;
    logic [10:0] w_dig;

    // minutes by 60
    logic [4:0]  w_hour;
    logic [5:0]  w_min;

    // stage 8: year within group
    logic [1:0]  r8_yi;
    logic [8:0]  r8_diy;
    logic [5:0]  r8_grp;
    logic [5:0]  r8_sec;
    logic [1:0]  w_yi;

    // stage 9: month, day, year, raw weekday sum
    logic [MonthW-1:0] r9_month;
    logic [DomW-1:0]   r9_dom;
    logic [YearW-1:0]  r9_year;
    logic [9:0]        r9_ws;
    logic [5:0]        r9_sec;
    logic [3:0]        w_mi;
    logic [8:0]        w_mstart;

    // stage 10: weekday reduced mod 7
    logic [MonthW-1:0] r10_month;
    logic [DomW-1:0]   r10_dom;
    logic [YearW-1:0]  r10_year;
    logic [WdayW-1:0]  r10_wd;
    logic [5:0]        r10_sec;

    // stage 11: output register
    logic [OutWidth-1:0] r_m_tdata;
    logic [OutWidth-1:0] w_pack;

    assign w_en       = ~r_vld[Stages] | i_m_tready;
    assign o_s_tready = w_en;
    assign o_m_tvalid = r_vld[Stages];
    assign o_m_tdata  = r_m_tdata;

    // valid pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[Stages-1:1], i_s_tvalid};
        end
    end

    // seconds / 128 by 675: days and second-of-day / 128
    epsc_cdiv #(.WN(25), .DIV(675), .WQ(16), .WR(10)) u_div_day (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r1_t[31:7]),
        .o_q   (w_days),
        .o_r   (w_sod_hi)
    );

    assign w_sod = {w_sod_hi, r4_low};

    // second of day by 60
    epsc_cdiv #(.WN(17), .DIV(60), .WQ(11), .WR(6)) u_div_sec (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (w_sod),
        .o_q   (w_min_total),
        .o_r   (w_sec)
    );

    // days into four-year groups
    epsc_cdiv #(.WN(16), .DIV(1461), .WQ(6), .WR(11)) u_div_grp (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (w_days),
        .o_q   (w_grp),
        .o_r   (w_dig)
    );

    // minute of day by 60
    epsc_cdiv #(.WN(11), .DIV(60), .WQ(5), .WR(6)) u_div_min (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (w_min_total),
        .o_q   (w_hour),
        .o_r   (w_min)
    );

    // year within the group: leap year first
    always_comb begin
        if (w_dig >= YearStart[3]) begin
            w_yi = 2'd3;
        end else if (w_dig >= YearStart[2]) begin
            w_yi = 2'd2;
        end else if (w_dig >= YearStart[1]) begin
            w_yi = 2'd1;
        end else begin
            w_yi = 2'd0;
        end
    end

    // month search: the compares form a thermometer code, pick the top set one
    always_comb begin
        logic [8:0] st;
        w_mi = 4'd0;
        for (int i = 1; i < 12; i++) begin
            st = (r8_yi == 2'd0) ? MonthStartLeap[i] : MonthStartNorm[i];
            if (r8_diy >= st) begin
                w_mi = 4'(i);
            end
        end
        w_mstart = (r8_yi == 2'd0) ? MonthStartLeap[w_mi] : MonthStartNorm[w_mi];
    end

    // final packing, all fields zero before 1980
    always_comb begin
        w_pack = '0;
        if (r_ok[Stages-1]) begin
            w_pack[0]     = 1'b1;
            w_pack[12:1]  = r10_year;
            w_pack[16:13] = r10_month;
            w_pack[21:17] = r10_dom;
            w_pack[26:22] = w_hour;
            w_pack[32:27] = w_min;
            w_pack[38:33] = r10_sec;
            w_pack[41:39] = r10_wd;
        end
    end

    // payload pipeline
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ok <= {r_ok[Stages-1:1], (i_s_tdata >= EpochShift)};
            // stage 1
            r1_t <= i_s_tdata - EpochShift;
            // stages 2..4
            r2_low <= r1_t[6:0];
            r3_low <= r2_low;
            r4_low <= r3_low;
            // stage 8
            r8_yi  <= w_yi;
            r8_diy <= 9'(w_dig - YearStart[w_yi]);
            r8_grp <= w_grp;
            r8_sec <= w_sec;
            // stage 9
            r9_month <= w_mi + 4'd1;
            r9_dom   <= DomW'(r8_diy - w_mstart + 9'd1);
            r9_year  <= BaseYear + {4'd0, r8_grp, 2'd0} + 12'(r8_yi);
            r9_ws    <= 10'(r8_grp) * 10'd5 + 10'(WeekOffset[r8_yi]) + 10'(r8_diy);
            r9_sec   <= r8_sec;
            // stage 10
            r10_month <= r9_month;
            r10_dom   <= r9_dom;
            r10_year  <= r9_year;
            r10_wd    <= mod7_10(r9_ws);
            r10_sec   <= r9_sec;
            // stage 11
            r_m_tdata <= w_pack;
        end
    end

    // a stall freezes the valid pipe
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("valid pipe moved during a stall");

    // a pre-1980 result carries only zeros
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tdata[0]) |-> (o_m_tdata[47:1] == 47'd0))
        else $error("pre-1980 result has nonzero fields");

    // a valid date has month and day in range
    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[0]) |->
        (o_m_tdata[16:13] != 4'd0 && o_m_tdata[16:13] <= 4'd12 &&
         o_m_tdata[21:17] != 5'd0))
        else $error("month or day out of range");

    // a valid time and weekday are in range
    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[0]) |->
        (o_m_tdata[26:22] <= 5'd23 && o_m_tdata[32:27] <= 6'd59 &&
         o_m_tdata[38:33] <= 6'd59 && o_m_tdata[41:39] != 3'd7))
        else $error("time of day or weekday out of range");

endmodule

FILE: tb/sv/tb_top.sv
// self-checking testbench for the epoch seconds to calendar converter
module tb_top;
    import epsc_pkg::*;

    // one decoded calendar result
    typedef struct {
        logic        ok;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  mday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  sec;
        logic [2:0]  wday;
        logic [5:0]  pad;
    } t_calendar;

    localparam int unsigned Epoch1980 = 32'd315504000;
    localparam int unsigned DaySecs   = 86400;
    localparam int unsigned GroupDays = 1461;
    localparam int          MaxGap    = 18;
    localparam int          LongHold  = 400;

    logic                i_clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_valid = 1'b0;
    logic [InWidth-1:0]  s_data = '0;
    logic                s_ready;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [OutWidth-1:0] m_data;

    t_calendar pending_dates[$];
    int        err_count = 0;
    bit        tx_idle = 1'b1;
    bit        rx_idle = 1'b1;
    int        hold_cycles = 0;

    epoch_seconds_to_calendar_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (s_ready),
        .i_s_tdata  (s_data),    // [31:0] unix_seconds
        .o_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        .o_m_tdata  (m_data)     // [0] valid_res, [12:1] year, [16:13] month,
                                 // [21:17] day_of_month, [26:22] hour,
                                 // [32:27] minute, [38:33] second,
                                 // [41:39] weekday, [47:42] zero
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // calendar date of a unix seconds count, every fourth year taken as leap
    function automatic t_calendar to_calendar(input logic [31:0] secs);
        t_calendar   c;
        int unsigned t;
        int unsigned days;
        int unsigned groups;
        int unsigned yi;
        int unsigned mi;
        int unsigned ylen;
        int unsigned mlen;
        int unsigned month_len [12];
        int unsigned year_offs [4];
        month_len = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        year_offs = '{1, 3, 4, 5};
        c = '{default: '0};
        if (secs < Epoch1980) begin
            return c;
        end
        t = secs - Epoch1980;
        c.sec    = 6'(t % 60);
        t        = t / 60;
        c.minute = 6'(t % 60);
        t        = t / 60;
        c.hour   = 5'(t % 24);
        t        = t / 24;
        days   = t % GroupDays;
        groups = t / GroupDays;
        // walk the years of the group, the first one is leap
        yi = 0;
        ylen = 366;
        while (yi < 3 && days >= ylen) begin
            days = days - ylen;
            yi++;
            ylen = 365;
        end
        c.wday = 3'((5 * groups + year_offs[yi] + days) % 7);
        // walk the months of that year
        mi = 0;
        mlen = month_len[0];
        while (mi < 11 && days >= mlen) begin
            days = days - mlen;
            mi++;
            mlen = (mi == 1 && yi == 0) ? 29 : month_len[mi];
        end
        c.ok    = 1'b1;
        c.year  = 12'(1980 + 4 * groups + yi);
        c.month = 4'(mi + 1);
        c.mday  = 5'(days + 1);
        return c;
    endfunction

    // offer one request, record its expected date when accepted
    task automatic send_seconds(input logic [31:0] secs);
        int gap;
        gap = tx_idle ? $urandom_range(0, MaxGap) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= secs;
        do begin
            @(posedge i_clk);
        end while (!s_ready);
        pending_dates.push_back(to_calendar(secs));
    endtask

    task automatic compare_field(input string name, input logic [11:0] want,
                                 input logic [11:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endtask

    // result side: random ready gaps, one long hold on demand
    initial begin
        t_calendar want;
        int        gap;
        wait (rst_n);
        forever begin
            if (hold_cycles > 0) begin
                gap = hold_cycles;
                hold_cycles = 0;
            end else begin
                gap = rx_idle ? $urandom_range(0, MaxGap) : 0;
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_ready <= 1'b1;
            do begin
                @(posedge i_clk);
            end while (m_valid !== 1'b1);
            if (pending_dates.size() == 0) begin
                $error("result with no request pending, tdata %h", m_data);
                err_count++;
            end else begin
                want = pending_dates.pop_front();
                compare_field("valid_res",    12'(want.ok),     12'(m_data[0]));
                compare_field("year",         want.year,        m_data[12:1]);
                compare_field("month",        12'(want.month),  12'(m_data[16:13]));
                compare_field("day_of_month", 12'(want.mday),   12'(m_data[21:17]));
                compare_field("hour",         12'(want.hour),   12'(m_data[26:22]));
                compare_field("minute",       12'(want.minute), 12'(m_data[32:27]));
                compare_field("second",       12'(want.sec),    12'(m_data[38:33]));
                compare_field("weekday",      12'(want.wday),   12'(m_data[41:39]));
                compare_field("pad",          12'(want.pad),    12'(m_data[47:42]));
            end
        end
    end

    // boundaries of the epoch, years, leap days and the field extremes
    task automatic test_directed();
        int unsigned picks [$];
        picks = '{
            32'd0, 32'd1, 32'd315503999, 32'd315504000, 32'd315504001,
            32'd315590399,                 // end of the first day
            32'd320601600, 32'd320688000,  // feb 29 and mar 1 of a leap year
            32'd347126399, 32'd347126400,  // year end after a leap year
            32'd352137600, 32'd352224000,  // feb 28 and mar 1 of a normal year
            32'd441734399, 32'd441734400,  // end of a four-year group
            32'd951753600,                 // leap day in 2000
            32'd4102415999,                // last second of 2099
            32'd4107513600, 32'd4107600000, // 2100 taken as leap
            32'h7FFFFFFF, 32'h80000000, 32'h55555555, 32'hAAAAAAAA,
            32'hFFFFFFFE, 32'hFFFFFFFF
        };
        foreach (picks[i]) begin
            send_seconds(picks[i]);
        end
    endtask

    // mix of pre-1980, day edges and uniform times
    task automatic test_random(input int count);
        int unsigned secs;
        int unsigned d;
        int          kind;
        repeat (count) begin
            kind = $urandom_range(0, 7);
            if (kind == 0) begin
                secs = $urandom_range(0, Epoch1980 - 1);
            end else if (kind <= 3) begin
                // first or last second of a random day
                d = $urandom_range(0, 46057);
                secs = Epoch1980 + d * DaySecs;
                if ($urandom_range(0, 1)) begin
                    secs = secs + DaySecs - 1;
                end
            end else begin
                secs = $urandom();
                if (secs < Epoch1980) begin
                    secs = secs + Epoch1980;
                end
            end
            send_seconds(secs);
        end
    endtask

    // back to back on both sides
    task automatic test_streaming(input int count);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        test_random(count);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    // output held off while requests keep coming, pipeline fills and stalls
    task automatic test_backpressure(input int count);
        tx_idle = 1'b0;
        hold_cycles = LongHold;
        test_random(count);
        tx_idle = 1'b1;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(600);
        test_streaming(200);
        test_backpressure(100);
        test_random(520);
        s_valid <= 1'b0;
        while (pending_dates.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (Stages + 5) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
design/epsc_pkg.sv
design/epsc_cdiv.sv
design/epoch_seconds_to_calendar_top.sv
tb/sv/tb_top.sv
